FILE: rtl/tpcs_pkg.sv
// Package for the token pair cancel stack: sizes, request and token codes,
// and the byte decode and cancel functions.
// No dependencies.
package tpcs_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int BAL_W       = 16;

  // request codes
  localparam logic [1:0] FUNC_FEED  = 2'd0;
  localparam logic [1:0] FUNC_FETCH = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_UNBAL = 2'd1;
  localparam logic [1:0] STAT_OVF   = 2'd2;

  typedef logic [2:0] token_t;

  // token codes, index into "+-><.,[]"
  localparam token_t CODE_INC   = 3'd0;
  localparam token_t CODE_DEC   = 3'd1;
  localparam token_t CODE_RIGHT = 3'd2;
  localparam token_t CODE_LEFT  = 3'd3;
  localparam token_t CODE_OUT   = 3'd4;
  localparam token_t CODE_IN    = 3'd5;
  localparam token_t CODE_OPEN  = 3'd6;
  localparam token_t CODE_CLOSE = 3'd7;

  typedef struct packed {
    logic   is_cmd;
    token_t code;
  } decode_t;

  function automatic decode_t code_of(input logic [7:0] b);
    decode_t d;
    d.is_cmd = 1'b1;
    case (b)
      8'h2B:   d.code = CODE_INC;
      8'h2D:   d.code = CODE_DEC;
      8'h3E:   d.code = CODE_RIGHT;
      8'h3C:   d.code = CODE_LEFT;
      8'h2E:   d.code = CODE_OUT;
      8'h2C:   d.code = CODE_IN;
      8'h5B:   d.code = CODE_OPEN;
      8'h5D:   d.code = CODE_CLOSE;
      default: begin
        d.is_cmd = 1'b0;
        d.code   = CODE_INC;
      end
    endcase
    return d;
  endfunction

  function automatic logic [7:0] cmd_char(input token_t c);
    logic [7:0] r;
    case (c)
      CODE_INC:   r = 8'h2B;
      CODE_DEC:   r = 8'h2D;
      CODE_RIGHT: r = 8'h3E;
      CODE_LEFT:  r = 8'h3C;
      CODE_OUT:   r = 8'h2E;
      CODE_IN:    r = 8'h2C;
      CODE_OPEN:  r = 8'h5B;
      default:    r = 8'h5D;
    endcase
    return r;
  endfunction

  function automatic logic cancels(input token_t top, input token_t c);
    return (top == CODE_INC   && c == CODE_DEC)   ||
           (top == CODE_DEC   && c == CODE_INC)   ||
           (top == CODE_RIGHT && c == CODE_LEFT)  ||
           (top == CODE_LEFT  && c == CODE_RIGHT) ||
           (top == CODE_OPEN  && c == CODE_CLOSE);
  endfunction

endpackage

FILE: rtl/token_pair_cancel_stack_core.sv
// Top level of the token pair cancel stack: request register, single-pass
// update logic, token memory and result register.
// Depends on tpcs_pkg.

// Each request is taken into the request register and its result into
// the result register, so the sustained rate is one request per clock
// while out_ready keeps the result register free. A feed
// keeps only the eight command characters; a kept byte either cancels the
// top of stack (pop) or is pushed, a push onto a full stack sets the
// overflow status until the next clear. The top entry and the entry at
// the fetch pointer are both kept in registers that the token memory
// refreshes every cycle from the next-state addresses (with write
// bypass), so back-to-back pushes, pops and fetches run without stalls.
// Each request yields exactly one result. The token memory has no reset
// and no clearing pass; a clear only zeroes the counters and the overflow flag.
module token_pair_cancel_stack_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 func,
  input  logic [7:0]                 in_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_char,
  output logic                       out_has_entry,
  output logic                       out_last,
  output logic [tpcs_pkg::CNT_W-1:0] out_depth,
  output logic [1:0]                 out_status
);
  import tpcs_pkg::*;

  // request register
  logic       s_valid;
  logic [1:0] s_func;
  logic [7:0] s_byte;

  // architectural state
  logic [CNT_W-1:0]        count, count_next;
  logic [CNT_W-1:0]        rp, rp_next;
  logic signed [BAL_W-1:0] bal, bal_next;
  logic                    ovf, ovf_next;

  // token memory and its registered read ports
  token_t               mem [STACK_DEPTH];
  token_t               top_data;    // mem[count-1]
  token_t               fetch_data;  // mem[rp]
  logic [ADDR_W-1:0]    top_addr, fetch_addr, waddr;
  logic                 we;
  token_t               wdata;
  logic [CNT_W-1:0]     top_idx;

  decode_t    dec;
  logic       advance;
  logic [7:0] r_char;
  logic       r_has, r_last;
  logic [1:0] r_status;

  // the request register moves on when the result register is free
  assign advance  = s_valid && (!out_valid || out_ready);
  assign in_ready = !s_valid || advance;
  assign dec      = code_of(s_byte);

  always_comb begin
    count_next = count;
    rp_next    = rp;
    bal_next   = bal;
    ovf_next   = ovf;
    we         = 1'b0;
    wdata      = dec.code;
    waddr      = count[ADDR_W-1:0];
    r_char     = 8'd0;
    r_has      = 1'b0;
    r_last     = 1'b0;
    if (advance) begin
      case (s_func)
        FUNC_FEED: begin
          if (dec.is_cmd) begin
            // saturating bracket balance, counted even on overflow
            if (dec.code == CODE_OPEN && bal != {1'b0, {(BAL_W-1){1'b1}}}) begin
              bal_next = bal + BAL_W'(1);
            end else if (dec.code == CODE_CLOSE && bal != {1'b1, {(BAL_W-1){1'b0}}}) begin
              bal_next = bal - BAL_W'(1);
            end
            if (count != '0 && cancels(top_data, dec.code)) begin
              count_next = count - CNT_W'(1);
            end else if (count == CNT_W'(STACK_DEPTH)) begin
              ovf_next = 1'b1;
            end else begin
              we         = 1'b1;
              count_next = count + CNT_W'(1);
            end
          end
        end
        FUNC_FETCH: begin
          if (rp < count) begin
            r_char  = cmd_char(fetch_data);
            r_has   = 1'b1;
            r_last  = (rp + CNT_W'(1)) == count;
            rp_next = rp + CNT_W'(1);
          end
        end
        FUNC_CLEAR: begin
          count_next = '0;
          rp_next    = '0;
          bal_next   = '0;
          ovf_next   = 1'b0;
        end
        default: begin
        end
      endcase
    end
    if (ovf_next) begin
      r_status = STAT_OVF;
    end else if (bal_next != '0) begin
      r_status = STAT_UNBAL;
    end else begin
      r_status = STAT_OK;
    end
  end

  // read addresses follow the next state; an empty stack wraps harmlessly
  assign top_idx    = count_next - CNT_W'(1);
  assign top_addr   = top_idx[ADDR_W-1:0];
  assign fetch_addr = rp_next[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    top_data   <= (we && waddr == top_addr)   ? wdata : mem[top_addr];
    fetch_data <= (we && waddr == fetch_addr) ? wdata : mem[fetch_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid   <= 1'b0;
      out_valid <= 1'b0;
      count     <= '0;
      rp        <= '0;
      bal       <= '0;
      ovf       <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s_valid <= 1'b1;
      end else if (advance) begin
        s_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      count <= count_next;
      rp    <= rp_next;
      bal   <= bal_next;
      ovf   <= ovf_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_func <= func;
      s_byte <= in_byte;
    end
    if (advance) begin
      out_char      <= r_char;
      out_has_entry <= r_has;
      out_last      <= r_last;
      out_depth     <= count_next;
      out_status    <= r_status;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_last_has: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_has_entry)
    else $error("last flag without a fetched entry");

  a_fetch_depth: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_has_entry |-> out_depth != '0 && out_char != 8'd0)
    else $error("fetch returned an entry from an empty stack");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    advance && s_func == FUNC_CLEAR |=> count == '0 && rp == '0 && !ovf)
    else $error("clear did not restart the state");

  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_status == STAT_OK || out_status == STAT_UNBAL ||
                  out_status == STAT_OVF)
    else $error("status code out of range");
`endif

endmodule
